// ===== rtl/clnw_pkg.sv =====
package clnw_pkg;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned PULSE_W             = 20;
  localparam logic [PULSE_W-1:0] PULSE_RESET  = 20'd7200;
  localparam int unsigned INIT_STROBES        = 6;
  localparam int unsigned IDX_W               = 3;
  localparam int unsigned UNITS_W             = 3;

  typedef enum logic [1:0] {
    MODE_DATA = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_INIT = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_INIT = 1'b1
  } kind_t;

  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] CMD_LINE2     = 8'hC0;
  localparam logic [7:0] FONT_LOW      = 8'hA0;
  localparam logic [7:0] FONT_HIGH_BASE = 8'hC0;
  localparam logic [7:0] CYR_YO_UPPER  = 8'hA8;
  localparam logic [7:0] CYR_YO_LOWER  = 8'hB8;
  localparam logic [7:0] LCD_YO        = 8'hA2;

  // Work item handed from the front end to the strobe sequencer.
  typedef struct packed {
    kind_t      kind;
    logic       rs;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [1:0] pre_wait;
    logic [1:0] post_wait;
    logic       last;
  } strobe_t;

  localparam logic [7:0] CYR_HI [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  localparam logic [3:0] INIT_NIB  [INIT_STROBES] = '{4'd3, 4'd3, 4'd3, 4'd2, 4'd2, 4'd8};
  localparam logic [1:0] INIT_POST [INIT_STROBES] = '{2'd3, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1};

  function automatic logic [7:0] map_font(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= FONT_HIGH_BASE) begin
      r = CYR_HI[b[5:0]];
    end else if (b inside {CYR_YO_UPPER, CYR_YO_LOWER}) begin
      r = LCD_YO;
    end
    return r;
  endfunction

  // Fields of strobe number idx of a queued item.
  function automatic strobe_t strobe_of(input entry_t e, input logic [IDX_W-1:0] idx);
    strobe_t s;
    if (e.kind == KIND_INIT) begin
      s.rs        = 1'b0;
      s.nibble    = INIT_NIB[idx];
      s.pre_wait  = (idx == '0) ? 2'd3 : 2'd0;
      s.post_wait = INIT_POST[idx];
      s.last      = (idx == IDX_W'(INIT_STROBES - 1));
    end else begin
      s.rs        = e.rs;
      s.nibble    = (idx == '0) ? e.data[7:4] : e.data[3:0];
      s.pre_wait  = 2'd0;
      s.post_wait = 2'd1;
      s.last      = (idx != '0);
    end
    return s;
  endfunction

endpackage

// ===== rtl/char_lcd_nibble_writer_top.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_stall  | data_byte[7:0], mode[1:0]
// output   | out_valid / out_stall| register_select, nibble[3:0], pre_wait[1:0],
//          |                      | post_wait[1:0], last
// config   | cfg_we               | cfg_wdata[19:0] (pulse_cycles)
//
// Strobe timing is counted in units of pulse_cycles by the unit timer in the back
// end; a byte is two strobes and init is six strobes.
// Input is taken while the queue has room; carriage returns and mode 3 are always taken.
// Reset is synchronous, empties the queue and sets pulse_cycles to 7200.
// A stalled result holds its fields; the timer resumes after the transfer.
module char_lcd_nibble_writer_top #(
  parameter int unsigned QUEUE_DEPTH = clnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [clnw_pkg::PULSE_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    data_byte,
  input  logic [1:0]                    mode,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          register_select,
  output logic [3:0]                    nibble,
  output logic [1:0]                    pre_wait,
  output logic [1:0]                    post_wait,
  output logic                          last
);

  clnw_pkg::entry_t  q_entry;
  clnw_pkg::entry_t  head;
  clnw_pkg::strobe_t strobe;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  clnw_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .mode      (mode),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  clnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  clnw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .strobe    (strobe)
  );

  assign register_select = strobe.rs;
  assign nibble          = strobe.nibble;
  assign pre_wait        = strobe.pre_wait;
  assign post_wait       = strobe.post_wait;
  assign last            = strobe.last;

endmodule

// ===== rtl/clnw_front.sv =====
module clnw_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic [1:0]            mode,
  input  logic                  q_full,
  output logic                  q_push,
  output clnw_pkg::entry_t      q_entry
);

  logic keep;

  always_comb begin
    keep            = 1'b1;
    q_entry.kind    = clnw_pkg::KIND_BYTE;
    q_entry.rs      = 1'b0;
    q_entry.data    = data_byte;
    case (clnw_pkg::mode_t'(mode))
      clnw_pkg::MODE_DATA: begin
        if (data_byte == clnw_pkg::BYTE_CR) begin
          keep = 1'b0;
        end else if (data_byte == clnw_pkg::BYTE_LF) begin
          q_entry.data = clnw_pkg::CMD_LINE2;
        end else begin
          q_entry.rs = 1'b1;
          if (data_byte > clnw_pkg::FONT_LOW) begin
            q_entry.data = clnw_pkg::map_font(data_byte);
          end
        end
      end
      clnw_pkg::MODE_CMD: begin
        q_entry.rs = 1'b0;
      end
      clnw_pkg::MODE_INIT: begin
        q_entry.kind = clnw_pkg::KIND_INIT;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Items that cause no strobe are taken even when the queue is full.
  assign in_stall = q_full && keep;
  assign q_push   = in_valid && !in_stall && keep;

endmodule

// ===== rtl/clnw_queue.sv =====
module clnw_queue #(
  parameter int unsigned DEPTH = clnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  clnw_pkg::entry_t push_entry,
  input  logic             pop,
  output clnw_pkg::entry_t head,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  clnw_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/clnw_back.sv =====
module clnw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [clnw_pkg::PULSE_W-1:0]  cfg_wdata,
  input  clnw_pkg::entry_t              head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output clnw_pkg::strobe_t             strobe
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PRE  = 4'b0010,
    S_SHOW = 4'b0100,
    S_POST = 4'b1000
  } state_t;

  state_t                          state;
  clnw_pkg::entry_t                cur;
  logic [clnw_pkg::IDX_W-1:0]      idx;
  logic [clnw_pkg::UNITS_W-1:0]    units;
  logic [clnw_pkg::PULSE_W-1:0]    cyc;
  logic [clnw_pkg::PULSE_W-1:0]    pulse_cycles;
  clnw_pkg::strobe_t               cur_strobe;
  clnw_pkg::strobe_t               next_strobe;
  logic                            unit_done;

  assign cur_strobe  = clnw_pkg::strobe_of(cur, idx);
  assign next_strobe = clnw_pkg::strobe_of(cur, idx + 1'b1);
  // A pulse_cycles setting of zero ends each unit at once.
  assign unit_done   = (pulse_cycles == '0) || (cyc == pulse_cycles - 1'b1);
  assign pop         = (state == S_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_cycles <= clnw_pkg::PULSE_RESET;
    end else if (cfg_we) begin
      pulse_cycles <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_PRE && units == '0) begin
      strobe <= cur_strobe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      units     <= '0;
      cyc       <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!empty) begin
            idx   <= '0;
            cyc   <= '0;
            units <= (head.kind == clnw_pkg::KIND_INIT) ? 3'd3 : 3'd0;
            state <= S_PRE;
          end
        end
        S_PRE: begin
          if (units == '0) begin
            out_valid <= 1'b1;
            state     <= S_SHOW;
          end else if (unit_done) begin
            cyc   <= '0;
            units <= units - 1'b1;
          end else begin
            cyc <= cyc + 1'b1;
          end
        end
        S_SHOW: begin
          if (!out_stall) begin
            // Drop out_valid once the strobe is taken, then count the post wait.
            out_valid <= 1'b0;
            cyc       <= '0;
            units     <= {1'b0, strobe.post_wait} + 3'd1;
            state     <= S_POST;
          end
        end
        S_POST: begin
          if (units == '0) begin
            if (cur_strobe.last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              cyc   <= '0;
              units <= {1'b0, next_strobe.pre_wait};
              state <= S_PRE;
            end
          end else if (unit_done) begin
            cyc   <= '0;
            units <= units - 1'b1;
          end else begin
            cyc <= cyc + 1'b1;
          end
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule
